// ----- hw/rtl/ucm_pkg.sv -----
// ----------------------------------------------------------------------------
// ucm_pkg
// Shared types and constants for the UTF-8 / Latin-1 case mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package ucm_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;
  } out_item_t;

  // One queue entry: the results caused by one input byte (one or two beats)
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } res_pair_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

endpackage

`default_nettype wire

// ----- hw/rtl/ucm_front.sv -----
// ----------------------------------------------------------------------------
// ucm_front
// Accepts string bytes, tracks sequence state and builds the result entries.
// ----------------------------------------------------------------------------
`default_nettype none

module ucm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  ucm_pkg::in_item_t in_item,
  input  logic              upper_mode,
  input  logic              q_full,
  output logic              q_push,
  output ucm_pkg::res_pair_t q_data
);
  import ucm_pkg::*;

  localparam logic [7:0]  CASE_DELTA8  = 8'h20;
  localparam logic [10:0] CASE_DELTA11 = 11'h020;

  logic [1:0] cont_left, cont_left_next;
  logic [4:0] held_bits, held_bits_next;
  logic       pending,   pending_next;
  logic       err_seen,  err_seen_next;

  logic       accept;
  logic       has_res;
  logic       bad;
  logic [7:0] b;
  logic       last;
  logic [10:0] cp;
  logic [10:0] cp_mapped;
  res_pair_t  ent;

  function automatic logic [7:0] map_ascii(input logic [7:0] v, input logic up);
    logic [7:0] r;
    r = v;
    if (up && v >= 8'h61 && v <= 8'h7A) begin
      r = v - CASE_DELTA8;
    end else if (!up && v >= 8'h41 && v <= 8'h5A) begin
      r = v + CASE_DELTA8;
    end
    return r;
  endfunction

  function automatic logic [10:0] map_latin1(input logic [10:0] v, input logic up);
    logic [10:0] r;
    r = v;
    if (up && v >= 11'h0E0 && v <= 11'h0FE && v != 11'h0F7) begin
      r = v - CASE_DELTA11;
    end else if (!up && v >= 11'h0C0 && v <= 11'h0DE && v != 11'h0D7) begin
      r = v + CASE_DELTA11;
    end
    return r;
  endfunction

  assign b         = in_item.in_byte;
  assign last      = in_item.in_last;
  assign full      = q_full;
  assign accept    = push && !q_full;
  assign q_push    = accept && has_res;
  assign q_data    = ent;
  assign cp        = {held_bits, b[5:0]};
  assign cp_mapped = map_latin1(cp, upper_mode);

  always_comb begin
    has_res        = 1'b0;
    bad            = 1'b0;
    ent            = '0;
    cont_left_next = cont_left;
    held_bits_next = held_bits;
    pending_next   = pending;
    err_seen_next  = err_seen;

    if (err_seen) begin
      // rest of a failed string is dropped; only its end is reported
      if (last) begin
        has_res             = 1'b1;
        ent.first.out_last  = 1'b1;
        ent.first.out_error = 1'b1;
      end
    end else if (pending) begin
      if (b[7:6] != 2'b10) begin
        bad = 1'b1;
      end else begin
        has_res              = 1'b1;
        ent.two              = 1'b1;
        ent.first.out_byte   = {3'b110, cp_mapped[10:6]};
        ent.second.out_byte  = {2'b10, cp_mapped[5:0]};
        ent.second.out_last  = last;
        pending_next         = 1'b0;
        held_bits_next       = '0;
      end
    end else if (cont_left != 2'd0) begin
      if (b[7:6] != 2'b10 || (last && cont_left > 2'd1)) begin
        bad = 1'b1;
      end else begin
        has_res            = 1'b1;
        ent.first.out_byte = b;
        ent.first.out_last = last;
        cont_left_next     = cont_left - 2'd1;
      end
    end else if (!b[7]) begin
      has_res            = 1'b1;
      ent.first.out_byte = map_ascii(b, upper_mode);
      ent.first.out_last = last;
    end else if (b[7:5] == 3'b110) begin
      if (last) begin
        bad = 1'b1;
      end else begin
        held_bits_next = b[4:0];
        pending_next   = 1'b1;
      end
    end else if (b[7:4] == 4'b1110) begin
      if (last) begin
        bad = 1'b1;
      end else begin
        has_res            = 1'b1;
        ent.first.out_byte = b;
        cont_left_next     = 2'd2;
      end
    end else if (b[7:3] == 5'b11110) begin
      if (last) begin
        bad = 1'b1;
      end else begin
        has_res            = 1'b1;
        ent.first.out_byte = b;
        cont_left_next     = 2'd3;
      end
    end else begin
      bad = 1'b1;
    end

    if (bad) begin
      has_res             = 1'b1;
      ent                 = '0;
      ent.first.out_last  = last;
      ent.first.out_error = 1'b1;
      err_seen_next       = 1'b1;
    end

    if (last) begin
      cont_left_next = '0;
      held_bits_next = '0;
      pending_next   = 1'b0;
      err_seen_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cont_left <= '0;
      held_bits <= '0;
      pending   <= 1'b0;
      err_seen  <= 1'b0;
    end else if (accept) begin
      cont_left <= cont_left_next;
      held_bits <= held_bits_next;
      pending   <= pending_next;
      err_seen  <= err_seen_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ucm_queue.sv -----
// ----------------------------------------------------------------------------
// ucm_queue
// Short register queue of result entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ucm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  ucm_pkg::res_pair_t wr_data,
  output logic               q_full,
  input  logic               rd,
  output logic               q_empty,
  output ucm_pkg::res_pair_t head
);
  import ucm_pkg::*;

  res_pair_t        slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;
  logic [QAW:0]     count_next;

  assign q_full  = (count == QDEPTH[QAW:0]);
  assign q_empty = (count == '0);
  assign head    = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr && !rd) begin
      count_next = count + 1'b1;
    end else if (rd && !wr) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ucm_back.sv -----
// ----------------------------------------------------------------------------
// ucm_back
// Splits queue entries into single result beats for the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module ucm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  ucm_pkg::res_pair_t head,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output ucm_pkg::out_item_t out_item
);
  import ucm_pkg::*;

  logic sub;     // second beat of a two-beat entry is showing
  logic taken;

  assign empty    = q_empty;
  assign out_item = sub ? head.second : head.first;
  assign taken    = pop && !q_empty;
  assign q_pop    = taken && (!head.two || sub);

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (taken) begin
      sub <= head.two && !sub;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_latin1_case_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_latin1_case_mapper_unit
// UTF-8 string case mapper for ASCII and Latin-1 supplement letters.
// ----------------------------------------------------------------------------
// Input channel: push / full, one string byte per beat with a last flag.
// Output channel: empty / pop, one mapped byte per beat with last and error.
// The results of an accepted byte are registered in the result queue, whose
// head drives the output beats. One byte is taken every cycle while the
// four-entry result queue has room; a two-byte lead gives no beat and its
// continuation gives two, so pairs average one beat per byte.
// On an invalid string a single beat with error set and a zero byte is
// given, later bytes are dropped, and the last byte gives a final error beat.
// upper_mode (cfg_wr_en / cfg_wr_data) selects upper (1) or lower (0) case;
// write it only while the block is idle.
// Reset empties the queue, clears the sequence state and sets lower case.
// When the receiver stalls the queue fills and full rises; no beat is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_latin1_case_mapper_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               push,
  output logic               full,
  input  ucm_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output ucm_pkg::out_item_t out_item
);
  import ucm_pkg::*;

  logic      upper_mode;
  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  res_pair_t q_data;
  res_pair_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      upper_mode <= cfg_wr_data;
    end
  end

  ucm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .upper_mode (upper_mode),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  ucm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_data),
    .q_full  (q_full),
    .rd      (q_pop),
    .q_empty (q_empty),
    .head    (head)
  );

  ucm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ucm_checker.sv -----
// ----------------------------------------------------------------------------
// ucm_assertions
// Port-level checks on the case mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ucm_assertions (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input ucm_pkg::in_item_t  in_item,
  input logic               empty,
  input logic               pop,
  input ucm_pkg::out_item_t out_item
);
  import ucm_pkg::*;

  // nothing waits on the output straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // an error beat carries a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.out_error) |-> (out_item.out_byte == 8'h00))
    else $error("error beat with non-zero byte");

  // no beat appears without a byte having been taken
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (empty && !(push && !full)) |=> empty)
    else $error("result beat appeared without input");

  // an ASCII last byte always yields a beat next cycle
  a_ascii_out: assert property (@(posedge clk) disable iff (rst)
    (push && !full && empty && in_item.in_last && !in_item.in_byte[7]) |=> !empty)
    else $error("accepted byte gave no beat");

  // a stalled beat stays on offer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting beat withdrawn");

endmodule

bind utf8_latin1_case_mapper_unit ucm_assertions u_ucm_assertions (.*);

`default_nettype wire
